// ===== rtl/yelr_pkg.sv =====
// Constants and fixed-point widths for the luma remap pixel pipeline.
package yelr_pkg;

	localparam int FRAC_BITS = 16;

	// Unsigned coefficient width: the largest coefficient is below two.
	localparam int CUW = FRAC_BITS + 1;
	// Signed coefficient width for the chroma-to-RGB products.
	localparam int CSW = FRAC_BITS + 2;
	// Width of an 8-bit channel times an unsigned coefficient.
	localparam int PW = FRAC_BITS + 9;
	// Signed width of a chroma difference.
	localparam int CDW = FRAC_BITS + 10;
	// Signed width of a chroma product with 2*FRAC_BITS fraction bits.
	localparam int MW = CSW + CDW;
	// Signed width of an output channel before truncation and clamping.
	localparam int SW = MW + 1;

	localparam longint FX_ONE = longint'(1) << FRAC_BITS;
	localparam longint FX_HALF = longint'(1) << (FRAC_BITS - 1);

	// Each coefficient is round(c * 2^FRAC_BITS) with halves rounded up.
	localparam longint C_Y_R = (longint'(299000) * FX_ONE + longint'(500000)) / 1000000;
	localparam longint C_Y_G = (longint'(587000) * FX_ONE + longint'(500000)) / 1000000;
	localparam longint C_CB_R = (longint'(168736) * FX_ONE + longint'(500000)) / 1000000;
	localparam longint C_CR_G = (longint'(418688) * FX_ONE + longint'(500000)) / 1000000;
	localparam longint C_R_CR = (longint'(1402000) * FX_ONE + longint'(500000)) / 1000000;
	localparam longint C_G_CB = (longint'(344136) * FX_ONE + longint'(500000)) / 1000000;
	localparam longint C_G_CR = (longint'(714136) * FX_ONE + longint'(500000)) / 1000000;
	localparam longint C_B_CB = (longint'(1772000) * FX_ONE + longint'(500000)) / 1000000;

	// The luma weights sum to exactly one and each chroma row to exactly zero.
	localparam logic [CUW-1:0] K_Y_R = CUW'(C_Y_R);
	localparam logic [CUW-1:0] K_Y_G = CUW'(C_Y_G);
	localparam logic [CUW-1:0] K_Y_B = CUW'(FX_ONE - C_Y_R - C_Y_G);
	localparam logic [CUW-1:0] K_CB_R = CUW'(C_CB_R);
	localparam logic [CUW-1:0] K_CB_G = CUW'(FX_HALF - C_CB_R);
	localparam logic [CUW-1:0] K_CR_G = CUW'(C_CR_G);
	localparam logic [CUW-1:0] K_CR_B = CUW'(FX_HALF - C_CR_G);
	localparam logic [CUW-1:0] K_R_CR = CUW'(C_R_CR);
	localparam logic [CUW-1:0] K_G_CB = CUW'(C_G_CB);
	localparam logic [CUW-1:0] K_G_CR = CUW'(C_G_CR);
	localparam logic [CUW-1:0] K_B_CB = CUW'(C_B_CB);

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_PIXEL = 1'b1;

	// Truncate toward zero and clamp to 0..255.
	function automatic logic [7:0] to_channel(input logic signed [SW-1:0] v);
		logic [7:0] res;
		if (v <= 0) begin
			res = 8'd0;
		end else if (v[SW-2:2*FRAC_BITS+8] != '0) begin
			res = 8'd255;
		end else begin
			res = v[2*FRAC_BITS+7:2*FRAC_BITS];
		end
		return res;
	endfunction

endpackage

// ===== rtl/ycbcr_equalized_luma_remap_top.sv =====
// Luma remap pixel pipeline: RGB to YCbCr, table lookup on luma, back to RGB.
//
// The block takes one request per clock while in_stall is low and has four
// register stages: channel products, YCbCr sums and table address, table read
// with chroma products, and clamped RGB output. A pixel request returns its
// result from the output stage; a table-write request returns nothing. The
// 256 x 8 remap table is a single-port memory accessed between the second
// and third stages, so table writes and pixel lookups take effect strictly
// in request order. Every entry a pixel can reach must be written before
// that pixel is sent; unwritten entries read as unknown. Empty stages fill
// under an output stall, so up to four requests are held while the output
// waits.
module ycbcr_equalized_luma_remap_top
	import yelr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       func,
	input  logic [7:0] lut_index,
	input  logic [7:0] lut_value,
	input  logic [7:0] in_red,
	input  logic [7:0] in_green,
	input  logic [7:0] in_blue,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_red,
	output logic [7:0] out_green,
	output logic [7:0] out_blue
);

	logic en1, en2, en3, en4;
	logic v_s1, v_s2, v_s3, v_s4;

	// Stage 1 payload.
	logic           func_s1;
	logic [7:0]     lidx_s1, lval_s1, red_s1, blue_s1;
	logic [PW-1:0]  p_yr_s1, p_yg_s1, p_yb_s1;
	logic [PW-1:0]  p_cbr_s1, p_cbg_s1, p_crg_s1, p_crb_s1;

	// Stage 2 payload.
	logic                  func_s2;
	logic [7:0]            addr_s2, lval_s2;
	logic signed [CDW-1:0] cb_s2, cr_s2;

	// Stage 3 payload.
	logic [7:0]           lut_s3;
	logic signed [MW-1:0] m_rcr_s3, m_gcb_s3, m_gcr_s3, m_bcb_s3;

	// Stage 4 payload.
	logic [7:0] red_s4, green_s4, blue_s4;

	logic [7:0] remap_mem [256];

	logic [PW:0]           ysum_c;
	logic [7:0]            yidx_c;
	logic signed [CDW-1:0] hr_c, hb_c, cbr_c, cbg_c, crg_c, crb_c, cb_c, cr_c;
	logic signed [CSW-1:0] k_rcr_c, k_gcb_c, k_gcr_c, k_bcb_c;
	logic signed [SW-1:0]  yeq_c, sr_c, sg_c, sb_c;

	// A stage loads when it is empty or when its contents move on.
	assign en4 = !v_s4 || !out_stall;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;
	assign out_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			// Table writes end at the memory; only pixels go on.
			if (en3) v_s3 <= v_s2 && (func_s2 == FUNC_PIXEL);
			if (en4) v_s4 <= v_s3;
		end
	end

	// Stage 1: constant products of each channel.
	always_ff @(posedge clk) begin
		if (en1) begin
			func_s1  <= func;
			lidx_s1  <= lut_index;
			lval_s1  <= lut_value;
			red_s1   <= in_red;
			blue_s1  <= in_blue;
			p_yr_s1  <= PW'(in_red) * PW'(K_Y_R);
			p_yg_s1  <= PW'(in_green) * PW'(K_Y_G);
			p_yb_s1  <= PW'(in_blue) * PW'(K_Y_B);
			p_cbr_s1 <= PW'(in_red) * PW'(K_CB_R);
			p_cbg_s1 <= PW'(in_green) * PW'(K_CB_G);
			p_crg_s1 <= PW'(in_green) * PW'(K_CR_G);
			p_crb_s1 <= PW'(in_blue) * PW'(K_CR_B);
		end
	end

	// Stage 2: luma, chroma differences and the table address.
	assign ysum_c = (PW+1)'(p_yr_s1) + (PW+1)'(p_yg_s1) + (PW+1)'(p_yb_s1);
	assign yidx_c = (ysum_c[PW:FRAC_BITS+8] != '0) ? 8'd255
		: ysum_c[FRAC_BITS+7:FRAC_BITS];

	assign hr_c  = CDW'(red_s1) << (FRAC_BITS - 1);
	assign hb_c  = CDW'(blue_s1) << (FRAC_BITS - 1);
	assign cbr_c = CDW'(p_cbr_s1);
	assign cbg_c = CDW'(p_cbg_s1);
	assign crg_c = CDW'(p_crg_s1);
	assign crb_c = CDW'(p_crb_s1);
	assign cb_c  = hb_c - cbr_c - cbg_c;
	assign cr_c  = hr_c - crg_c - crb_c;

	always_ff @(posedge clk) begin
		if (en2) begin
			func_s2 <= func_s1;
			addr_s2 <= (func_s1 == FUNC_PIXEL) ? yidx_c : lidx_s1;
			lval_s2 <= lval_s1;
			cb_s2   <= cb_c;
			cr_s2   <= cr_c;
		end
	end

	// Stage 3: table access in request order, and the chroma products.
	assign k_rcr_c = CSW'(K_R_CR);
	assign k_gcb_c = CSW'(K_G_CB);
	assign k_gcr_c = CSW'(K_G_CR);
	assign k_bcb_c = CSW'(K_B_CB);

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			if (func_s2 == FUNC_WRITE) begin
				remap_mem[addr_s2] <= lval_s2;
			end
			lut_s3 <= remap_mem[addr_s2];
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			m_rcr_s3 <= MW'(k_rcr_c) * MW'(cr_s2);
			m_gcb_s3 <= MW'(k_gcb_c) * MW'(cb_s2);
			m_gcr_s3 <= MW'(k_gcr_c) * MW'(cr_s2);
			m_bcb_s3 <= MW'(k_bcb_c) * MW'(cb_s2);
		end
	end

	// Stage 4: add the remapped luma, truncate and clamp.
	assign yeq_c = SW'(lut_s3) << (2 * FRAC_BITS);
	assign sr_c  = yeq_c + SW'(m_rcr_s3);
	assign sg_c  = yeq_c - SW'(m_gcb_s3) - SW'(m_gcr_s3);
	assign sb_c  = yeq_c + SW'(m_bcb_s3);

	always_ff @(posedge clk) begin
		if (en4) begin
			red_s4   <= to_channel(sr_c);
			green_s4 <= to_channel(sg_c);
			blue_s4  <= to_channel(sb_c);
		end
	end

	assign out_red   = red_s4;
	assign out_green = green_s4;
	assign out_blue  = blue_s4;

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the luma remap pixel pipeline with randomized handshakes.
module tb_top;
	import yelr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Fixed-point weights, rebuilt here from the BT.601 constants.
	localparam int FB = yelr_pkg::FRAC_BITS;
	localparam longint ONE = longint'(1) << FB;
	localparam longint HALF = longint'(1) << (FB - 1);
	localparam longint W_Y_R = (longint'(299000) * ONE + 500000) / 1000000;
	localparam longint W_Y_G = (longint'(587000) * ONE + 500000) / 1000000;
	localparam longint W_Y_B = ONE - W_Y_R - W_Y_G;
	localparam longint W_CB_R = (longint'(168736) * ONE + 500000) / 1000000;
	localparam longint W_CB_G = HALF - W_CB_R;
	localparam longint W_CR_G = (longint'(418688) * ONE + 500000) / 1000000;
	localparam longint W_CR_B = HALF - W_CR_G;
	localparam longint W_R_CR = (longint'(1402000) * ONE + 500000) / 1000000;
	localparam longint W_G_CB = (longint'(344136) * ONE + 500000) / 1000000;
	localparam longint W_G_CR = (longint'(714136) * ONE + 500000) / 1000000;
	localparam longint W_B_CB = (longint'(1772000) * ONE + 500000) / 1000000;

	localparam int RANDOM_REQS = 1350;
	localparam int IDLE_LIMIT = 400;
	localparam int N_ROWS = 24;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		logic       func;
		logic [7:0] idx;
		logic [7:0] val;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} req_t;

	typedef struct packed {
		req_t rq;
		logic typed_ok;
		rgb_t typed;
	} row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic       func;
	logic [7:0] lut_index;
	logic [7:0] lut_value;
	logic [7:0] in_red;
	logic [7:0] in_green;
	logic [7:0] in_blue;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;

	logic [7:0] remap_lut [0:255];
	bit         lut_written [0:255];
	rgb_t       remapped_q[$];
	int         mismatch_cnt = 0;
	int         idle_cycles = 0;
	int         stall_left = 0;
	int         out_taken = 0;
	int         out_seen = 0;
	bit         in_calm = 0;
	bit         out_calm = 0;
	row_t       dir_rows [0:N_ROWS-1];

	ycbcr_equalized_luma_remap_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.lut_index(lut_index),
		.lut_value(lut_value),
		.in_red(in_red),
		.in_green(in_green),
		.in_blue(in_blue),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_red(out_red),
		.out_green(out_green),
		.out_blue(out_blue)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [7:0] luma_level(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		longint y;
		longint lvl;
		y = W_Y_R * longint'(r) + W_Y_G * longint'(g) + W_Y_B * longint'(b);
		lvl = y >>> FB;
		if (lvl > 255) begin
			lvl = 255;
		end
		return lvl[7:0];
	endfunction

	function automatic logic [7:0] clamp_channel(input longint v);
		longint w;
		if (v <= 0) begin
			return 8'd0;
		end
		w = v >>> (2 * FB);
		return (w > 255) ? 8'd255 : w[7:0];
	endfunction

	function automatic rgb_t remap_pixel(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		longint rr, gg, bb, cb, cr, yeq;
		rgb_t res;
		rr = longint'(r);
		gg = longint'(g);
		bb = longint'(b);
		cb = HALF * bb - W_CB_R * rr - W_CB_G * gg;
		cr = HALF * rr - W_CR_G * gg - W_CR_B * bb;
		yeq = longint'(remap_lut[luma_level(r, g, b)]) * (ONE * ONE);
		res.r = clamp_channel(yeq + W_R_CR * cr);
		res.g = clamp_channel(yeq - W_G_CB * cb - W_G_CR * cr);
		res.b = clamp_channel(yeq + W_B_CB * cb);
		return res;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_req(input req_t rq, input bit typed_ok, input rgb_t typed);
		int gap;
		if ($urandom_range(0, 39) == 0) begin
			in_calm = !in_calm;
		end
		gap = in_calm ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		func <= rq.func;
		lut_index <= rq.idx;
		lut_value <= rq.val;
		in_red <= rq.r;
		in_green <= rq.g;
		in_blue <= rq.b;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		if (rq.func == FUNC_WRITE) begin
			remap_lut[rq.idx] = rq.val;
			lut_written[rq.idx] = 1'b1;
		end else begin
			remapped_q.push_back(typed_ok ? typed : remap_pixel(rq.r, rq.g, rq.b));
		end
		@(negedge clk);
	endtask

	// A pixel whose level has no table entry yet gets one written just ahead of it.
	task automatic send_checked(input req_t rq, input bit typed_ok, input rgb_t typed);
		req_t wr;
		logic [7:0] lvl;
		lvl = luma_level(rq.r, rq.g, rq.b);
		if (rq.func == FUNC_PIXEL && !lut_written[lvl]) begin
			wr = '{FUNC_WRITE, lvl, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
			send_req(wr, 1'b0, '0);
		end
		send_req(rq, typed_ok, typed);
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (remapped_q.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_component();
		int sel;
		sel = $urandom_range(0, 7);
		if (sel == 0) begin
			return 8'd0;
		end else if (sel == 1) begin
			return 8'd255;
		end
		return 8'($urandom);
	endfunction

	task automatic check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t %s: expected %0d, got %0d", $time, name, exp_v, act_v);
			mismatch_cnt++;
		end
	endtask

	// Result checker.
	always @(posedge clk) begin
		rgb_t e;
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			if (remapped_q.size() == 0) begin
				$display("%0t unexpected pixel result: got %0d %0d %0d", $time,
					out_red, out_green, out_blue);
				mismatch_cnt++;
			end else begin
				e = remapped_q.pop_front();
				check_field("out_red", e.r, out_red);
				check_field("out_green", e.g, out_green);
				check_field("out_blue", e.b, out_blue);
			end
			out_taken++;
		end
	end

	// Output stall generator: a new wait is drawn after each accepted result.
	always @(negedge clk) begin
		if (out_seen != out_taken) begin
			out_seen = out_taken;
			if ($urandom_range(0, 29) == 0) begin
				out_calm = !out_calm;
			end
			stall_left = out_calm ? 0 : $urandom_range(0, 13);
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Watchdog: too long without any request or result moving ends the run.
	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0) ||
				(out_valid === 1'b1 && out_stall === 1'b0)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		req_t rq;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_WRITE;
		lut_index = 8'd0;
		lut_value = 8'd0;
		in_red = 8'd0;
		in_green = 8'd0;
		in_blue = 8'd0;
		for (int i = 0; i < 256; i++) begin
			remap_lut[i] = 8'd0;
			lut_written[i] = 1'b0;
		end

		// Gray pixels have zero chroma, so they come back as the table entry itself.
		dir_rows = '{
			'{'{FUNC_WRITE, 8'd0, 8'd0, 8'hFF, 8'hFF, 8'hFF}, 1'b0, '0},
			'{'{FUNC_PIXEL, 8'hFF, 8'hFF, 8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 8'd0, 8'd0}},
			'{'{FUNC_WRITE, 8'd255, 8'd255, 8'hAA, 8'h55, 8'hAA}, 1'b0, '0},
			'{'{FUNC_PIXEL, 8'h55, 8'hAA, 8'd255, 8'd255, 8'd255}, 1'b1,
				'{8'd255, 8'd255, 8'd255}},
			'{'{FUNC_WRITE, 8'd128, 8'd200, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
			'{'{FUNC_PIXEL, 8'd0, 8'd0, 8'd128, 8'd128, 8'd128}, 1'b1,
				'{8'd200, 8'd200, 8'd200}},
			'{'{FUNC_WRITE, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255}, 1'b0, '0},
			'{'{FUNC_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1'b1,
				'{8'd0, 8'd0, 8'd0}},
			'{'{FUNC_WRITE, 8'd76, 8'd255, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
			'{'{FUNC_PIXEL, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0}, 1'b0, '0},
			'{'{FUNC_WRITE, 8'd149, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
			'{'{FUNC_PIXEL, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0}, 1'b0, '0},
			'{'{FUNC_WRITE, 8'd29, 8'd128, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
			'{'{FUNC_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255}, 1'b0, '0},
			'{'{FUNC_WRITE, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
			'{'{FUNC_PIXEL, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1}, 1'b1, '{8'd1, 8'd1, 8'd1}},
			'{'{FUNC_WRITE, 8'd254, 8'd254, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
			'{'{FUNC_PIXEL, 8'd0, 8'd0, 8'd254, 8'd254, 8'd254}, 1'b1,
				'{8'd254, 8'd254, 8'd254}},
			'{'{FUNC_WRITE, 8'd76, 8'd0, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
			'{'{FUNC_PIXEL, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0}, 1'b0, '0},
			'{'{FUNC_WRITE, 8'd225, 8'd255, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
			'{'{FUNC_PIXEL, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0}, 1'b0, '0},
			'{'{FUNC_WRITE, 8'd178, 8'd17, 8'd0, 8'd0, 8'd0}, 1'b0, '0},
			'{'{FUNC_PIXEL, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255}, 1'b0, '0}
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			send_checked(dir_rows[i].rq, dir_rows[i].typed_ok, dir_rows[i].typed);
		end
		wait_results_done();

		for (int n = 0; n < RANDOM_REQS; n++) begin
			rq.idx = 8'($urandom);
			rq.val = 8'($urandom);
			rq.r = pick_component();
			rq.g = pick_component();
			rq.b = pick_component();
			if ($urandom_range(0, 15) == 0) begin
				rq.g = rq.r;
				rq.b = rq.r;
			end
			rq.func = ($urandom_range(0, 3) == 0) ? FUNC_WRITE : FUNC_PIXEL;
			send_checked(rq, 1'b0, '0);
			if (n == RANDOM_REQS / 2) begin
				wait_results_done();
			end
		end

		wait_results_done();
		repeat (16) @(posedge clk);
		if (mismatch_cnt == 0 && remapped_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/yelr_pkg.sv
rtl/ycbcr_equalized_luma_remap_top.sv
test/tb_top.sv
